// File: sv/sspi_pkg.sv
// Package for the sorted sample interpolator: table entry type, phase codes and
// the divider widths. It depends on nothing else.
package sspi_pkg;

   // One table entry as held in the sample memory.
   typedef struct packed {
      logic [31:0]        stamp;
      logic [15:0]        depth;
      logic signed [15:0] temp;
      logic               has_temp;
      logic               has_depth;
   } entry_type;

   // Width of the signed dividend and of the divisor of the serial divider.
   localparam int DIV_W   = 52;
   localparam int DVS_W   = 32;
   localparam int DCNT_W  = 6;

   // Result phases that follow the table walk.
   typedef enum logic [1:0] {
      PH_DEPTH = 2'd0,
      PH_TEMP  = 2'd1,
      PH_AVG   = 2'd2
   } phase_type;

   // Bracketing points found for one quantity during a query walk.
   typedef struct packed {
      logic               have0;
      logic signed [16:0] v0;
      logic [31:0]        t0;
      logic               have1;
      logic signed [16:0] v1;
      logic [31:0]        t1;
   } track_type;

endpackage

// File: sv/sspi_mem.sv
// Sample memory of the sorted sample interpolator: one write and one read port,
// read data registered. Uses sspi_pkg for the entry type.
module sspi_mem #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  sspi_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output sspi_pkg::entry_type rd_data
);
   import sspi_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sspi_div.sv
// Serial signed divider, one quotient bit a cycle, used for the interpolation
// and the average. Uses sspi_pkg for its widths.
module sspi_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [sspi_pkg::DIV_W-1:0] dividend,
   input  logic [sspi_pkg::DVS_W-1:0]       divisor,
   output logic                             done,
   output logic signed [15:0]               quotient
);
   import sspi_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DCNT_W-1:0]   cnt_ff, cnt_in;
   logic [DIV_W-1:0]    quo_ff, quo_in;
   logic [DVS_W-1:0]    rem_ff, rem_in;
   logic [DVS_W-1:0]    dvs_ff, dvs_in;
   logic                neg_ff, neg_in;
   logic [DVS_W:0]      shifted;
   logic [DVS_W+1:0]    diff;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(DIV_W);
         quo_in  = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
         rem_in  = '0;
         dvs_in  = divisor;
         neg_in  = dividend[DIV_W-1];
      end else if (busy_ff) begin
         if (diff[DVS_W+1]) begin
            rem_in = shifted[DVS_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end else begin
            rem_in = diff[DVS_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(quo_ff[15:0]) : $signed(quo_ff[15:0]);

endmodule

// File: sv/sorted_sample_interpolator_unit.sv
// Top level of the sorted sample interpolator: control sequencer, statistics
// and result register. Uses sspi_pkg, sspi_mem and sspi_div.
//
// The block keeps up to TABLE_DEPTH samples in time order in one synchronous
// memory and answers one request at a time. An insert walks the table from its
// top end downwards, moving each later entry up one place (each moved entry is
// read, then written), and then writes the new sample and updates the average.
// A full table drops the insert and reports status 1. A query reads every held
// entry once through the memory's read port (one entry a cycle) and then runs
// up to three serial divisions, one each for the depth and the temperature
// interpolation and one for the average. The serial divider and the single
// memory read port bound the time an item takes. Reads and writes of the memory
// never fall on the same entry in one cycle, because each move reads an entry
// and only writes it one place higher in the following cycle. The memory needs
// no clearing after reset: only entries below the fill count are ever used.
// Results leave through an output register, so a new request is accepted while
// a result still waits.
module sorted_sample_interpolator_unit #(
   parameter int TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // From bit 0: sample_time[31:0], depth_in[47:32], depth_present[48],
   // temp_in[64:49], temp_present[65], zero fill[71:66].
   input  logic [71:0] req_tdata,
   // Bit 0: opcode (0 insert, 1 query).
   input  logic [0:0]  req_tuser,
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // From bit 0: status[0], depth_out[16:1], depth_valid[17], temp_out[33:18],
   // temp_valid[34], min_temp[50:35], max_temp[66:51], avg_temp[82:67],
   // entry_count[91:83], zero fill[95:92].
   output logic [95:0] rsp_tdata
);
   import sspi_pkg::*;

   localparam int AW   = $clog2(TABLE_DEPTH);
   localparam int CW   = $clog2(TABLE_DEPTH + 1);
   localparam int SUMW = 16 + CW;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_INS_RD = 10'b0000000010,
      ST_INS_WR = 10'b0000000100,
      ST_PUT    = 10'b0000001000,
      ST_SCAN   = 10'b0000010000,
      ST_CALC   = 10'b0000100000,
      ST_MUL    = 10'b0001000000,
      ST_SUM    = 10'b0010000000,
      ST_DIV    = 10'b0100000000,
      ST_OUT    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // Request fields held for the whole item.
   logic [31:0]        t_ff, t_in;
   logic [15:0]        dep_ff, dep_in;
   logic               dpres_ff, dpres_in;
   logic signed [15:0] tin_ff, tin_in;
   logic               tpres_ff, tpres_in;

   logic [CW-1:0]      fill_ff, fill_in;
   logic [CW-1:0]      k_ff, k_in;
   logic [CW-1:0]      km1;
   logic               pend_ff, pend_in;
   phase_type          phase_ff, phase_in;

   // Temperature statistics.
   logic signed [SUMW-1:0] sum_ff, sum_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic signed [15:0]     min_ff, min_in;
   logic signed [15:0]     max_ff, max_in;

   track_type trk_d_ff, trk_d_in, trk_t_ff, trk_t_in, trk;

   // Result fields.
   logic               status_ff, status_in;
   logic [15:0]        dval_ff, dval_in;
   logic               dvalid_ff, dvalid_in;
   logic signed [15:0] tval_ff, tval_in;
   logic               tvalid_ff, tvalid_in;
   logic signed [15:0] avg_ff, avg_in;

   // Multiply and divide path.
   logic signed [49:0]       p1_ff, p1_in;
   logic signed [50:0]       p2_ff, p2_in;
   logic signed [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [DVS_W-1:0]         dvs_ff, dvs_in;
   logic                     start_ff, start_in;
   logic                     div_done;
   logic signed [15:0]       div_q;
   logic signed [32:0]       gap_s, dt_s;
   logic signed [17:0]       dv;

   // Memory ports.
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type     wr_data, rd_data, new_entry;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff, rsp_data_in;
   logic [31:0] fill_wide;

   logic acc;

   assign req_tready = state_ff == ST_IDLE;
   assign acc        = req_tvalid && req_tready;
   assign km1        = k_ff - 1'b1;

   assign new_entry.stamp     = t_ff;
   assign new_entry.depth     = dep_ff;
   assign new_entry.temp      = tin_ff;
   assign new_entry.has_temp  = tpres_ff;
   assign new_entry.has_depth = dpres_ff;

   assign trk   = (phase_ff == PH_DEPTH) ? trk_d_ff : trk_t_ff;
   assign gap_s = $signed({1'b0, trk.t1 - trk.t0});
   assign dt_s  = $signed({1'b0, t_ff - trk.t0});
   assign dv    = 18'(trk.v1) - 18'(trk.v0);

   sspi_mem #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sspi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (dvd_ff),
      .divisor  (dvs_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      state_in  = state_ff;
      t_in      = t_ff;
      dep_in    = dep_ff;
      dpres_in  = dpres_ff;
      tin_in    = tin_ff;
      tpres_in  = tpres_ff;
      fill_in   = fill_ff;
      k_in      = k_ff;
      pend_in   = 1'b0;
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      trk_d_in  = trk_d_ff;
      trk_t_in  = trk_t_ff;
      status_in = status_ff;
      dval_in   = dval_ff;
      dvalid_in = dvalid_ff;
      tval_in   = tval_ff;
      tvalid_in = tvalid_ff;
      avg_in    = avg_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      start_in  = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = k_ff[AW-1:0];
      wr_data   = rd_data;
      rd_addr   = km1[AW-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               t_in      = req_tdata[31:0];
               dep_in    = req_tdata[47:32];
               dpres_in  = req_tdata[48];
               tin_in    = $signed(req_tdata[64:49]);
               tpres_in  = req_tdata[65];
               status_in = 1'b0;
               dval_in   = '0;
               dvalid_in = 1'b0;
               tval_in   = '0;
               tvalid_in = 1'b0;
               trk_d_in  = '0;
               trk_t_in  = '0;
               k_in      = '0;
               if (req_tuser[0]) begin
                  phase_in = PH_DEPTH;
                  state_in = ST_SCAN;
               end else if (fill_ff >= CW'(TABLE_DEPTH)) begin
                  status_in = 1'b1;
                  phase_in  = PH_AVG;
                  state_in  = ST_CALC;
               end else begin
                  k_in     = fill_ff;
                  state_in = (fill_ff == '0) ? ST_PUT : ST_INS_RD;
               end
            end
         end
         ST_INS_RD: begin
            // Read the entry just below the hole at k.
            state_in = ST_INS_WR;
         end
         ST_INS_WR: begin
            if (rd_data.stamp > t_ff) begin
               wr_en    = 1'b1;
               k_in     = km1;
               state_in = (km1 == '0) ? ST_PUT : ST_INS_RD;
            end else begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            wr_en   = 1'b1;
            wr_data = new_entry;
            fill_in = fill_ff + 1'b1;
            if (tpres_ff) begin
               if (cnt_ff == '0) begin
                  min_in = tin_ff;
                  max_in = tin_ff;
               end else begin
                  if (tin_ff < min_ff) min_in = tin_ff;
                  if (tin_ff > max_ff) max_in = tin_ff;
               end
               sum_in = sum_ff + SUMW'(tin_ff);
               cnt_in = cnt_ff + 1'b1;
            end
            phase_in = PH_AVG;
            state_in = ST_CALC;
         end
         ST_SCAN: begin
            rd_addr = k_ff[AW-1:0];
            if (pend_ff) begin
               if (rd_data.has_depth) begin
                  if (rd_data.stamp <= t_ff) begin
                     trk_d_in.have0 = 1'b1;
                     trk_d_in.v0    = $signed({1'b0, rd_data.depth});
                     trk_d_in.t0    = rd_data.stamp;
                  end else if (!trk_d_ff.have1) begin
                     trk_d_in.have1 = 1'b1;
                     trk_d_in.v1    = $signed({1'b0, rd_data.depth});
                     trk_d_in.t1    = rd_data.stamp;
                  end
               end
               if (rd_data.has_temp) begin
                  if (rd_data.stamp <= t_ff) begin
                     trk_t_in.have0 = 1'b1;
                     trk_t_in.v0    = 17'(rd_data.temp);
                     trk_t_in.t0    = rd_data.stamp;
                  end else if (!trk_t_ff.have1) begin
                     trk_t_in.have1 = 1'b1;
                     trk_t_in.v1    = 17'(rd_data.temp);
                     trk_t_in.t1    = rd_data.stamp;
                  end
               end
            end
            if (k_ff < fill_ff) begin
               pend_in = 1'b1;
               k_in    = k_ff + 1'b1;
            end else if (!pend_ff) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (phase_ff == PH_AVG) begin
               if (cnt_ff == '0) begin
                  avg_in   = '0;
                  state_in = ST_OUT;
               end else begin
                  dvd_in   = DIV_W'(sum_ff);
                  dvs_in   = DVS_W'(cnt_ff);
                  start_in = 1'b1;
                  state_in = ST_DIV;
               end
            end else if (trk.have0 && trk.have1 && trk.t1 != trk.t0) begin
               state_in = ST_MUL;
            end else begin
               // Single-sided cases, a zero time gap and an empty table.
               if (phase_ff == PH_DEPTH) begin
                  dvalid_in = trk.have0 || trk.have1;
                  dval_in   = trk.have0 ? 16'(trk.v0) : trk.have1 ? 16'(trk.v1) : '0;
                  phase_in  = PH_TEMP;
               end else begin
                  tvalid_in = trk.have0 || trk.have1;
                  tval_in   = trk.have0 ? 16'(trk.v0) : trk.have1 ? 16'(trk.v1) : '0;
                  phase_in  = PH_AVG;
               end
            end
         end
         ST_MUL: begin
            p1_in    = 50'(trk.v0) * 50'(gap_s);
            p2_in    = 51'(dv) * 51'(dt_s);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            dvd_in   = DIV_W'(p1_ff) + DIV_W'(p2_ff);
            dvs_in   = trk.t1 - trk.t0;
            start_in = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_CALC;
               case (phase_ff)
                  PH_DEPTH: begin
                     dvalid_in = 1'b1;
                     dval_in   = div_q;
                     phase_in  = PH_TEMP;
                  end
                  PH_TEMP: begin
                     tvalid_in = 1'b1;
                     tval_in   = div_q;
                     phase_in  = PH_AVG;
                  end
                  default: begin
                     avg_in   = div_q;
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, fill_wide[8:0], avg_ff, max_ff, min_ff,
                               tvalid_ff, tval_ff, dvalid_ff, dval_ff, status_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign fill_wide = 32'(fill_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         pend_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         pend_ff      <= pend_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t_ff        <= t_in;
      dep_ff      <= dep_in;
      dpres_ff    <= dpres_in;
      tin_ff      <= tin_in;
      tpres_ff    <= tpres_in;
      k_ff        <= k_in;
      phase_ff    <= phase_in;
      trk_d_ff    <= trk_d_in;
      trk_t_ff    <= trk_t_in;
      status_ff   <= status_in;
      dval_ff     <= dval_in;
      dvalid_ff   <= dvalid_in;
      tval_ff     <= tval_in;
      tvalid_ff   <= tvalid_in;
      avg_ff      <= avg_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      dvd_ff      <= dvd_in;
      dvs_ff      <= dvs_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
